### design/rtty_afsk_modulator_assert.svh
// Assertion macros shared by the modulator RTL.
`ifndef RTTY_AFSK_MODULATOR_ASSERT_SVH
`define RTTY_AFSK_MODULATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("modulator assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("modulator assertion failed");

`endif

### design/rtty_afsk_pkg.sv
package rtty_afsk_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_SAMPLE = 2'd3
    } t_kind;

    // Register indexes, taken from paddr[2].
    localparam logic REG_AFSK_MODE  = 1'b0;
    localparam logic REG_TONE_SHIFT = 1'b1;

    localparam int HALF_SINE_ENTRIES_DEF = 125;
    localparam int SINE_ROM_DEPTH        = 128;
    localparam int SINE_IDX_W            = 7;
    localparam int DAC_W                 = 16;
    localparam int FRAME_LEN             = 10;
    localparam int MAX_BITS              = 8;

    localparam logic [2:0] STEP_MARK  = 3'd4;
    localparam logic [2:0] STEP_SPACE = 3'd3;

    typedef struct packed {
        logic             done;
        logic             dac_valid;
        logic [DAC_W-1:0] value;
    } t_result;

    // First half of one sine period, offset to mid level 128. Entries past the
    // 125th sit at mid level.
    localparam logic [7:0] HALF_SINE [SINE_ROM_DEPTH] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd243,
        8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd250,
        8'd251, 8'd251, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252,
        8'd252, 8'd252, 8'd252, 8'd252, 8'd251, 8'd251, 8'd250, 8'd250,
        8'd249, 8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242,
        8'd241, 8'd239, 8'd238, 8'd236, 8'd235, 8'd233, 8'd231, 8'd230,
        8'd228, 8'd226, 8'd224, 8'd222, 8'd220, 8'd218, 8'd215, 8'd213,
        8'd211, 8'd208, 8'd206, 8'd203, 8'd201, 8'd198, 8'd196, 8'd193,
        8'd190, 8'd188, 8'd185, 8'd182, 8'd179, 8'd176, 8'd173, 8'd171,
        8'd168, 8'd165, 8'd162, 8'd159, 8'd156, 8'd152, 8'd149, 8'd146,
        8'd143, 8'd140, 8'd137, 8'd134, 8'd131, 8'd128, 8'd128, 8'd128
    };

endpackage

### design/rtty_afsk_modulator.sv
// Each result beat is registered in the output stage before it appears on m_axis.
// Throughput: one input beat per cycle; the two-entry output stage (result register plus
// skid register) lets input continue while one result waits, and tready drops only when both
// are full.
// Reset (synchronous, active low): idle, no frame armed, FSK mode, tone shift 0, phase 0,
// mark tone step, output stage empty.
`include "rtty_afsk_modulator_assert.svh"

module rtty_afsk_modulator
    import rtty_afsk_pkg::*;
#(
    parameter int HALF_SINE_ENTRIES = HALF_SINE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [7:0] payload, [11:8] bit_count, [15:12] zero
    input  logic [1:0]        s_axis_tuser,   // [1:0] kind

    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DAC_W-1:0]  m_axis_tdata,   // [15:0] dac_value
    output logic [0:0]        m_axis_tuser,   // [0] dac_valid
    output logic              m_axis_tlast,   // done_res

    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // The phase runs over one full period of 2 * HALF_SINE_ENTRIES samples.
    localparam int FULL_PERIOD = 2 * HALF_SINE_ENTRIES;
    localparam int PH_W        = $clog2(FULL_PERIOD);
    localparam int SUM_W       = PH_W + 1;
    localparam logic [SUM_W-1:0] FULL_LIM = SUM_W'(FULL_PERIOD);
    localparam logic [SUM_W-1:0] HALF_LIM = SUM_W'(HALF_SINE_ENTRIES);

    // ---------------------------------------------------------------------
    // Configuration registers. pready is tied high, so a write lands on the
    // access cycle. Address bit 2 selects the register.
    // ---------------------------------------------------------------------
    logic             r_afsk_mode;
    logic [DAC_W-1:0] r_tone_shift;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_afsk_mode  <= 1'b0;
            r_tone_shift <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_AFSK_MODE:  r_afsk_mode  <= pwdata[0];
                REG_TONE_SHIFT: r_tone_shift <= pwdata[DAC_W-1:0];
                default:        r_afsk_mode  <= r_afsk_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_AFSK_MODE:  prdata = {31'd0, r_afsk_mode};
            REG_TONE_SHIFT: prdata = {{(32 - DAC_W){1'b0}}, r_tone_shift};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Input unpacking.
    // ---------------------------------------------------------------------
    t_kind       in_kind;
    logic [7:0]  in_payload;
    logic [3:0]  in_count;
    logic        in_acc;

    assign in_kind    = t_kind'(s_axis_tuser);
    assign in_payload = s_axis_tdata[7:0];
    assign in_count   = s_axis_tdata[11:8];
    assign in_acc     = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------------
    // Modulator state. held_char and binary_shift are only read after a
    // load has written them, so they carry no reset.
    // ---------------------------------------------------------------------
    logic             r_tick_div,   n_tick_div;
    logic [7:0]       r_held_char,  n_held_char;
    logic [3:0]       r_sym_idx,    n_sym_idx;
    logic             r_armed,      n_armed;
    logic [7:0]       r_bin_shift,  n_bin_shift;
    logic [3:0]       r_bits_left,  n_bits_left;
    logic [PH_W-1:0]  r_phase,      n_phase;
    logic [2:0]       r_step,       n_step;

    logic             busy;
    logic             res_push;
    t_result          res;

    // Per-item datapath pieces.
    logic             sym_mark;
    logic             sym_send;
    logic             sym_done;
    logic [SUM_W-1:0] ph_sum;
    logic [SUM_W-1:0] ph_wrap;
    logic [SUM_W-1:0] rom_off;
    logic             ph_upper;
    logic [7:0]       rom_val;
    logic [7:0]       smp_val;

    assign busy = r_armed || (r_bits_left != '0);

    // Phase step: the stored phase is always below the period and the step
    // is at most 7, so one conditional subtract completes the modulo.
    always_comb begin
        ph_sum   = SUM_W'(r_phase) + SUM_W'(r_step);
        ph_wrap  = (ph_sum >= FULL_LIM) ? (ph_sum - FULL_LIM) : ph_sum;
        ph_upper = (ph_wrap >= HALF_LIM);
        rom_off  = ph_upper ? (ph_wrap - HALF_LIM) : ph_wrap;
        rom_val  = HALF_SINE[SINE_IDX_W'(rom_off)];
        // The second half period mirrors the table about mid level.
        smp_val  = ph_upper ? ~rom_val : rom_val;
    end

    always_comb begin
        n_tick_div  = r_tick_div;
        n_held_char = r_held_char;
        n_sym_idx   = r_sym_idx;
        n_armed     = r_armed;
        n_bin_shift = r_bin_shift;
        n_bits_left = r_bits_left;
        n_phase     = r_phase;
        n_step      = r_step;
        res_push    = 1'b0;
        res         = '0;
        sym_mark    = 1'b0;
        sym_send    = 1'b0;
        sym_done    = 1'b0;

        if (in_acc) begin
            case (in_kind)
                KIND_CHAR: begin
                    if (!busy) begin
                        n_held_char = in_payload;
                        n_sym_idx   = '0;
                        n_armed     = 1'b1;
                    end
                end
                KIND_BYTE: begin
                    // A zero count loads nothing; counts above eight send eight bits.
                    if (!busy && in_count != '0) begin
                        n_bin_shift = in_payload;
                        n_bits_left = (in_count > 4'(MAX_BITS)) ? 4'(MAX_BITS) : in_count;
                    end
                end
                KIND_SYMBOL: begin
                    // Ticks while idle are dropped and leave the divider alone.
                    if (busy) begin
                        n_tick_div = ~r_tick_div;
                        if (r_tick_div) begin
                            if (r_bits_left != '0) begin
                                // Binary bits go out MSB first and win over a frame.
                                sym_mark    = r_bin_shift[7];
                                sym_send    = 1'b1;
                                n_bin_shift = {r_bin_shift[6:0], 1'b0};
                                n_bits_left = r_bits_left - 4'd1;
                                sym_done    = (r_bits_left == 4'd1);
                            end else if (r_sym_idx < 4'(FRAME_LEN)) begin
                                // Start space, seven data bits LSB first, two stop marks.
                                if (r_sym_idx == '0) begin
                                    sym_mark = 1'b0;
                                end else if (r_sym_idx <= 4'd7) begin
                                    sym_mark = r_held_char[3'(r_sym_idx - 4'd1)];
                                end else begin
                                    sym_mark = 1'b1;
                                end
                                sym_send  = 1'b1;
                                n_sym_idx = r_sym_idx + 4'd1;
                            end else begin
                                // The send slot after the last stop mark reports done.
                                n_armed  = 1'b0;
                                sym_done = 1'b1;
                            end
                        end
                    end

                    if (sym_send) begin
                        if (r_afsk_mode) begin
                            n_step = sym_mark ? STEP_MARK : STEP_SPACE;
                        end else begin
                            res_push      = 1'b1;
                            res.dac_valid = 1'b1;
                            res.value     = sym_mark ? r_tone_shift : '0;
                        end
                    end
                    if (sym_done) begin
                        res_push = 1'b1;
                        res.done = 1'b1;
                    end
                end
                KIND_SAMPLE: begin
                    // In FSK mode there is no tone to advance.
                    if (r_afsk_mode) begin
                        n_phase       = PH_W'(ph_wrap);
                        res_push      = 1'b1;
                        res.dac_valid = 1'b1;
                        res.value     = {smp_val, 8'd0};
                    end
                end
                default: begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div  <= 1'b0;
            r_sym_idx   <= 4'(FRAME_LEN);
            r_armed     <= 1'b0;
            r_bits_left <= '0;
            r_phase     <= '0;
            r_step      <= STEP_MARK;
        end else begin
            r_tick_div  <= n_tick_div;
            r_sym_idx   <= n_sym_idx;
            r_armed     <= n_armed;
            r_bits_left <= n_bits_left;
            r_phase     <= n_phase;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_char <= n_held_char;
        r_bin_shift <= n_bin_shift;
    end

    // ---------------------------------------------------------------------
    // Output stage: a result register feeding m_axis and a skid register
    // behind it. Input is taken whenever the skid register is free, so
    // tready is a plain flop and one waiting result does not stall input.
    // ---------------------------------------------------------------------
    logic    r_out_vld, n_out_vld;
    logic    r_skd_vld, n_skd_vld;
    t_result r_out,     n_out;
    t_result r_skd,     n_skd;
    logic    out_pop;

    assign out_pop = r_out_vld && m_axis_tready;

    always_comb begin
        n_out_vld = r_out_vld;
        n_skd_vld = r_skd_vld;
        n_out     = r_out;
        n_skd     = r_skd;
        if (!r_out_vld || out_pop) begin
            if (r_skd_vld) begin
                n_out     = r_skd;
                n_out_vld = 1'b1;
                n_skd     = res;
                n_skd_vld = res_push;
            end else begin
                n_out     = res;
                n_out_vld = res_push;
            end
        end else if (res_push) begin
            n_skd     = res;
            n_skd_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign s_axis_tready   = !r_skd_vld;
    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out.value;
    assign m_axis_tuser[0] = r_out.dac_valid;
    assign m_axis_tlast    = r_out.done;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    // The skid register only fills behind a waiting result.
    `RAM_ASSERT_NOW(a_skid_behind_out, r_skd_vld, r_out_vld)
    // A sample tick in AFSK mode always leaves a result in the output stage.
    `RAM_ASSERT_NEXT(a_sample_gives_beat, in_acc && in_kind == KIND_SAMPLE && r_afsk_mode,
                     r_out_vld)
    // A nonzero binary load taken while idle makes the block busy.
    `RAM_ASSERT_NEXT(a_byte_load_busy,
                     in_acc && in_kind == KIND_BYTE && !busy && in_count != '0,
                     r_bits_left != '0 && r_bits_left <= 4'(MAX_BITS))
    // The phase never reaches the full period.
    `RAM_ASSERT_NOW(a_phase_in_range, 1'b1, SUM_W'(r_phase) < FULL_LIM)

endmodule

### tb/rtty_afsk_modulator_tb.sv
module rtty_afsk_modulator_tb
    import rtty_afsk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The sine tone covers 2*HALF_WAVE phase steps per period. The block runs
    // with its default table length.
    localparam int HALF_WAVE   = 125;
    localparam int CYCLE_LIMIT = 200000;

    // First half of one tone period, centered on mid level 128.
    localparam logic [7:0] SINE_HALF [HALF_WAVE] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd156,
        8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
        8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
        8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245,
        8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252,
        8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd251, 8'd251,
        8'd250, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242,
        8'd241, 8'd239, 8'd238, 8'd236, 8'd235, 8'd233, 8'd231, 8'd230, 8'd228, 8'd226,
        8'd224, 8'd222, 8'd220, 8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203,
        8'd201, 8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179, 8'd176,
        8'd173, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156, 8'd152, 8'd149, 8'd146,
        8'd143, 8'd140, 8'd137, 8'd134, 8'd131
    };

    // One input beat as the sender sees it.
    typedef struct {
        t_kind      kind;
        logic [7:0] payload;
        logic [3:0] bit_count;
    } t_tx_beat;

    // One predicted DAC/done beat, stamped with the time its cause was accepted.
    typedef struct {
        logic        done;
        logic        dac_valid;
        logic [15:0] value;
        longint      stamp;
    } t_dac_write;

    // Clock and reset. Every input has a known value from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] payload, [11:8] bit_count, [15:12] zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [15:0] dac_value
    logic [0:0]  m_axis_tuser;        // [0] dac_valid
    logic        m_axis_tlast;        // done_res

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rtty_afsk_modulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Beats waiting to be sent, and DAC/done beats the block still owes us.
    t_tx_beat   tx_beats[$];
    t_dac_write dac_writes_due[$];

    // Idle rates in percent for the sender and the receiver.
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    int errors = 0;
    int beats_sent = 0;
    int writes_checked = 0;
    int frames_loaded = 0;
    int bytes_loaded = 0;
    int tones_sampled = 0;
    int cycles = 0;

    // Shadow of the block: configuration and modulator state, at reset values.
    logic        cfg_afsk = 1'b0;
    logic [15:0] cfg_shift = '0;
    logic        half_tick = 1'b0;
    logic [7:0]  held_char = '0;
    int          sym_idx = FRAME_LEN;
    logic [7:0]  byte_shift = '0;
    int          bits_left = 0;
    logic [7:0]  tone_phase = '0;
    logic [2:0]  tone_step = STEP_MARK;
    logic        frame_armed = 1'b0;

    function automatic void owe_write(logic done, logic valid, logic [15:0] value);
        t_dac_write w;
        w.done = done;
        w.dac_valid = valid;
        w.value = value;
        w.stamp = $time;
        dac_writes_due.push_back(w);
    endfunction

    // Sends one symbol. In tone mode a symbol only retunes the oscillator, so
    // nothing is owed unless this symbol also ends the load.
    function automatic void send_symbol(logic mark, logic last);
        if (cfg_afsk) begin
            tone_step = mark ? STEP_MARK : STEP_SPACE;
            if (last) owe_write(1'b1, 1'b0, 16'h0000);
        end else begin
            owe_write(last, 1'b1, mark ? cfg_shift : 16'h0000);
        end
    endfunction

    // Advances the shadow by one accepted beat and records what it must emit.
    function automatic void modulate_beat(t_tx_beat b);
        logic busy;
        logic mark;
        int   ph;
        logic [7:0] level;
        busy = frame_armed || bits_left != 0;
        case (b.kind)
            KIND_CHAR: begin
                // Loads that arrive mid-transmission are dropped.
                if (!busy) begin
                    held_char = b.payload;
                    sym_idx = 0;
                    frame_armed = 1'b1;
                    frames_loaded++;
                end
            end
            KIND_BYTE: begin
                if (!busy && b.bit_count != 0) begin
                    byte_shift = b.payload;
                    bits_left = (b.bit_count > MAX_BITS) ? MAX_BITS : int'(b.bit_count);
                    bytes_loaded++;
                end
            end
            KIND_SYMBOL: begin
                // Ticks while idle leave the divider where it was.
                if (busy) begin
                    if (!half_tick) begin
                        half_tick = 1'b1;
                    end else begin
                        half_tick = 1'b0;
                        if (bits_left != 0) begin
                            // Raw bytes go out MSB first and win over a pending frame.
                            mark = byte_shift[7];
                            byte_shift = byte_shift << 1;
                            bits_left--;
                            send_symbol(mark, bits_left == 0);
                        end else if (sym_idx < FRAME_LEN) begin
                            // Start space, seven data bits LSB first, two stop marks.
                            if (sym_idx == 0) mark = 1'b0;
                            else if (sym_idx <= 7) mark = held_char[sym_idx-1];
                            else mark = 1'b1;
                            sym_idx++;
                            send_symbol(mark, 1'b0);
                        end else begin
                            frame_armed = 1'b0;
                            owe_write(1'b1, 1'b0, 16'h0000);
                        end
                    end
                end
            end
            default: begin
                // Sample ticks only matter in tone mode; the second half of the
                // period mirrors the table around mid level.
                if (cfg_afsk) begin
                    ph = (int'(tone_phase) + int'(tone_step)) % (2 * HALF_WAVE);
                    tone_phase = ph[7:0];
                    if (ph >= HALF_WAVE) level = 8'd255 - SINE_HALF[ph - HALF_WAVE];
                    else level = SINE_HALF[ph];
                    owe_write(1'b0, 1'b1, {level, 8'h00});
                    tones_sampled++;
                end
            end
        endcase
    endfunction

    // Driver: holds a beat until it is taken, then offers the next one unless
    // the sender decides to idle this cycle.
    t_tx_beat tx_cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                modulate_beat(tx_cur);
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_beats.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    tx_cur = tx_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'h0, tx_cur.bit_count, tx_cur.payload};
                    s_axis_tuser <= tx_cur.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result beat must match the oldest owed write. An owed write
    // stamped in this same cycle cannot be answered yet, since the block registers
    // each result before it appears.
    t_dac_write got_due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (dac_writes_due.size() == 0 || dac_writes_due[0].stamp >= $time) begin
                    $error("unexpected result beat: dac_value %h dac_valid %b done_res %b",
                           m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                    errors++;
                end else begin
                    got_due = dac_writes_due.pop_front();
                    writes_checked++;
                    if (m_axis_tuser[0] !== got_due.dac_valid) begin
                        $error("dac_valid: expected %b, got %b", got_due.dac_valid, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tdata !== got_due.value) begin
                        $error("dac_value: expected %h, got %h", got_due.value, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== got_due.done) begin
                        $error("done_res: expected %b, got %b", got_due.done, m_axis_tlast);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("rtty_afsk_modulator_tb: timeout after %0d cycles", cycles);
            $display("rtty_afsk_modulator_tb: done, errors");
            $finish;
        end
    end

    function automatic void queue_beat(t_kind kind, logic [7:0] payload, logic [3:0] count);
        t_tx_beat b;
        b.kind = kind;
        b.payload = payload;
        b.bit_count = count;
        tx_beats.push_back(b);
    endfunction

    // Waits until every beat has been sent and answered, then lets the pipeline
    // empty. Sampling at the falling edge keeps clear of the driver.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (tx_beats.size() != 0 || s_axis_tvalid || dac_writes_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Finishes any frame or byte still in progress so that the registers are
    // only touched while the modulator is idle.
    task automatic flush_modulator();
        int i;
        while (frame_armed || bits_left != 0) begin
            for (i = 0; i < 24; i++) queue_beat(KIND_SYMBOL, 8'h00, 4'h0);
            wait_quiet();
        end
    endtask

    // Two-phase register write; the register takes the value at the access edge.
    task automatic apb_write_reg(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_AFSK_MODE) cfg_afsk = value[0];
        else cfg_shift = value[15:0];
    endtask

    task automatic configure(input logic afsk, input logic [15:0] shift);
        flush_modulator();
        apb_write_reg(REG_AFSK_MODE, {31'd0, afsk});
        apb_write_reg(REG_TONE_SHIFT, {16'd0, shift});
        @(negedge i_clk);
    endtask

    // Random traffic: mostly complete characters and bytes with enough symbol
    // ticks to finish them, sample ticks sprinkled in, plus some noise such as
    // loads that land while the modulator is busy.
    task automatic make_traffic(input int quota, input int sample_pct);
        int made;
        int ticks;
        int i;
        int r;
        logic [3:0] count;
        made = 0;
        while (made < quota) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                queue_beat(KIND_CHAR, 8'($urandom), 4'($urandom));
                ticks = 2 * (FRAME_LEN + 1);
                made++;
            end else if (r < 88) begin
                // Mostly legal counts, now and then zero or above eight.
                if ($urandom_range(0, 7) == 0) count = 4'($urandom_range(0, 15));
                else count = 4'($urandom_range(1, 8));
                queue_beat(KIND_BYTE, 8'($urandom), count);
                ticks = 2 * ((count > MAX_BITS) ? MAX_BITS : int'(count));
                made++;
            end else begin
                queue_beat(t_kind'($urandom_range(0, 3)), 8'($urandom), 4'($urandom));
                ticks = $urandom_range(0, 4);
            end
            ticks += $urandom_range(0, 2);
            for (i = 0; i < ticks; i++) begin
                if ($urandom_range(0, 99) < sample_pct) begin
                    queue_beat(KIND_SAMPLE, 8'($urandom), 4'($urandom));
                    made++;
                end
                if ($urandom_range(0, 39) == 0)
                    queue_beat($urandom_range(0, 1) ? KIND_CHAR : KIND_BYTE,
                               8'($urandom), 4'($urandom));
                queue_beat(KIND_SYMBOL, 8'($urandom), 4'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        int i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 30;
        snk_idle_pct = 46;

        // Directed: level mode at full shift. Idle ticks, a dropped zero-count
        // load and a dropped character load, a one-bit mark byte, then an
        // all-space byte with an oversized count that is clipped to eight.
        configure(1'b0, 16'hFFFF);
        queue_beat(KIND_SYMBOL, 8'h00, 4'h0);
        queue_beat(KIND_SAMPLE, 8'hFF, 4'hF);
        queue_beat(KIND_BYTE, 8'hFF, 4'h0);
        queue_beat(KIND_BYTE, 8'h80, 4'h1);
        queue_beat(KIND_CHAR, 8'h41, 4'h0);
        queue_beat(KIND_SYMBOL, 8'h00, 4'h0);
        queue_beat(KIND_SYMBOL, 8'h00, 4'h0);
        queue_beat(KIND_BYTE, 8'h00, 4'hF);
        for (i = 0; i < 16; i++) queue_beat(KIND_SYMBOL, 8'hFF, 4'hF);
        wait_quiet();

        // Random phases: tone and level modes, across the shift extremes, with
        // the idle pattern moving from receiver-heavy to sender-heavy to none.
        configure(1'b1, 16'($urandom));
        make_traffic(380, 60);
        wait_quiet();

        src_idle_pct = 46;
        snk_idle_pct = 30;
        configure(1'b0, 16'($urandom));
        make_traffic(380, 15);
        wait_quiet();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        configure(1'b0, 16'h0000);
        make_traffic(150, 15);
        wait_quiet();

        configure(1'b1, 16'hFFFF);
        make_traffic(220, 60);
        wait_quiet();
        flush_modulator();
        repeat (10) @(negedge i_clk);

        $display("rtty_afsk_modulator_tb: %0d beats in, %0d result beats checked",
                 beats_sent, writes_checked);
        $display("rtty_afsk_modulator_tb: %0d characters, %0d raw bytes, %0d tone samples",
                 frames_loaded, bytes_loaded, tones_sampled);
        if (errors == 0) begin
            $display("rtty_afsk_modulator_tb: done, clean");
        end else begin
            $display("rtty_afsk_modulator_tb: done, errors");
        end
        $finish;
    end

endmodule
